// ===== rtl/mcps_pkg.sv =====
// mcps_pkg: constants, control word types and microcode table of the
// motor command packet scheduler; no dependencies
`default_nettype none

package mcps_pkg;

    // channel table size and field widths
    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;
    localparam int CH_CNT_W     = $clog2(NUM_CHANNELS + 1);
    localparam int DRIVE_W      = 9;
    localparam int BYTE_W       = 8;
    localparam int CFG_W        = 8;
    localparam int FRAME_LEN    = 1 + 2 + 1 + 1;

    // command codes
    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_XMIT = 1'b1;

    // microprogram step counter and step addresses
    typedef logic [3:0] pc_t;

    localparam pc_t STEP_FETCH = 4'd0;
    localparam pc_t STEP_SCAN  = 4'd1;
    localparam pc_t STEP_TEST  = 4'd2;
    localparam pc_t STEP_B0    = 4'd3;
    localparam pc_t STEP_B1    = 4'd4;
    localparam pc_t STEP_B2    = 4'd5;
    localparam pc_t STEP_B3    = 4'd6;
    localparam pc_t STEP_B4    = 4'd7;
    localparam pc_t STEP_SKIP  = 4'd8;

    // frame byte selector
    typedef enum logic [2:0] {
        SEL_CH,
        SEL_FWD,
        SEL_REV,
        SEL_XOR,
        SEL_SUM
    } sel_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IS_SET,
        C_CH_END,
        C_NOT_ELIG
    } cond_t;

    // one control word
    typedef struct packed {
        logic  accept;   // step waits for an input transfer
        logic  emit;     // step loads the output register, waits for room
        sel_t  sel;
        logic  ch_clr;
        logic  ch_inc;
        cond_t cond;
        pc_t   target;
    } ctrl_t;

    // microcode rom
    function automatic ctrl_t ucode_rom(input pc_t pc);
        ctrl_t w;
        w = '{accept: 1'b0, emit: 1'b0, sel: SEL_CH, ch_clr: 1'b0,
              ch_inc: 1'b0, cond: C_ALWAYS, target: STEP_FETCH};
        unique case (pc)
            STEP_FETCH: begin
                w.accept = 1'b1;
                w.ch_clr = 1'b1;
                w.cond   = C_IS_SET;
                w.target = STEP_FETCH;
            end
            STEP_SCAN: begin
                w.cond   = C_CH_END;
                w.target = STEP_FETCH;
            end
            STEP_TEST: begin
                w.cond   = C_NOT_ELIG;
                w.target = STEP_SKIP;
            end
            STEP_B0: begin
                w.emit = 1'b1;
                w.sel  = SEL_CH;
                w.cond = C_NEVER;
            end
            STEP_B1: begin
                w.emit = 1'b1;
                w.sel  = SEL_FWD;
                w.cond = C_NEVER;
            end
            STEP_B2: begin
                w.emit = 1'b1;
                w.sel  = SEL_REV;
                w.cond = C_NEVER;
            end
            STEP_B3: begin
                w.emit = 1'b1;
                w.sel  = SEL_XOR;
                w.cond = C_NEVER;
            end
            STEP_B4: begin
                w.emit   = 1'b1;
                w.sel    = SEL_SUM;
                w.ch_inc = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = STEP_SCAN;
            end
            STEP_SKIP: begin
                w.ch_inc = 1'b1;
                w.cond   = C_ALWAYS;
                w.target = STEP_SCAN;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/motor_command_packet_scheduler.sv =====
// motor command packet scheduler: channel table, microcoded sequencer and
// output register; depends on mcps_pkg
// a set command is taken at the fetch step; a transmit scans every channel and
// emits a frame for each one that is enabled and pending; the microcode step
// counter spends one step per emitted byte and three per skipped channel.
// one item is handled at a time; the output register lets the last byte wait
// while the next item is taken.
// reset (aresetn low, synchronous): drive table zero, pending flags all one,
// channel mask zero, output empty, sequencer at the fetch step.
`default_nettype none

module motor_command_packet_scheduler (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration
    input  wire logic                               cfg_wr_en,
    input  wire logic [mcps_pkg::CFG_W-1:0]         cfg_wr_data,
    // command channel
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_command,
    input  wire logic [mcps_pkg::CH_W-1:0]          s_channel,
    input  wire logic signed [mcps_pkg::DRIVE_W-1:0] s_drive_value,
    // frame byte channel
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [mcps_pkg::BYTE_W-1:0]             m_frame_byte,
    output logic                                    m_last_byte
);
    import mcps_pkg::*;

    logic [CFG_W-1:0]        enabled_reg;
    logic [DRIVE_W-1:0]      drive_reg [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] pending_reg;
    pc_t                     pc_reg, pc_next;
    logic [CH_CNT_W-1:0]     ch_reg, ch_next;
    logic                    m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]       m_byte_reg, m_byte_next;
    logic                    m_last_reg, m_last_next;

    ctrl_t                   ctrl;
    logic                    out_free;
    logic                    go;
    logic                    cond_hit;
    logic [CH_W-1:0]         rd_idx;
    logic [DRIVE_W-1:0]      rd_val;
    logic [NUM_CHANNELS-1:0] elig;
    logic                    more_after;
    logic                    set_fire;
    logic                    set_in_range;
    logic [DRIVE_W:0]        neg_val;
    logic [BYTE_W-1:0]       b_ch, b_fwd, b_rev, b_xor, b_sum, b_sel;

    // current control word
    assign ctrl = ucode_rom(pc_reg);

    // step advances when its input or output handshake allows
    assign out_free = !m_valid_reg || m_ready;
    assign go       = (!ctrl.accept || s_valid) && (!ctrl.emit || out_free);

    // table read port: command channel at fetch, scan pointer otherwise
    assign rd_idx = (pc_reg == STEP_FETCH) ? s_channel : ch_reg[CH_W-1:0];
    assign rd_val = drive_reg[rd_idx];

    // channels due for a frame
    assign elig = enabled_reg[NUM_CHANNELS-1:0] & pending_reg;

    // any due channel after the one being sent
    always_comb begin
        more_after = 1'b0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (elig[i] && (CH_CNT_W'(i) > ch_reg)) begin
                more_after = 1'b1;
            end
        end
    end

    // frame bytes of the current channel
    always_comb begin
        neg_val = -{rd_val[DRIVE_W-1], rd_val};
        b_ch    = BYTE_W'(ch_reg[CH_W-1:0]);
        b_fwd   = (!rd_val[DRIVE_W-1] && (rd_val != '0)) ? rd_val[BYTE_W-1:0] : '0;
        if (!rd_val[DRIVE_W-1]) begin
            b_rev = '0;
        end else if (neg_val[BYTE_W]) begin
            b_rev = '1;
        end else begin
            b_rev = neg_val[BYTE_W-1:0];
        end
        b_xor = b_ch ^ b_fwd ^ b_rev;
        b_sum = b_ch + b_fwd + b_rev;
    end

    always_comb begin
        unique case (ctrl.sel)
            SEL_CH:  b_sel = b_ch;
            SEL_FWD: b_sel = b_fwd;
            SEL_REV: b_sel = b_rev;
            SEL_XOR: b_sel = b_xor;
            SEL_SUM: b_sel = b_sum;
            default: b_sel = b_ch;
        endcase
    end

    // jump condition
    always_comb begin
        unique case (ctrl.cond)
            C_NEVER:    cond_hit = 1'b0;
            C_ALWAYS:   cond_hit = 1'b1;
            C_IS_SET:   cond_hit = (s_command == CMD_SET);
            C_CH_END:   cond_hit = (ch_reg == CH_CNT_W'(NUM_CHANNELS));
            C_NOT_ELIG: cond_hit = !elig[ch_reg[CH_W-1:0]];
            default:    cond_hit = 1'b1;
        endcase
    end

    // sequencer next state
    always_comb begin
        pc_next = pc_reg;
        ch_next = ch_reg;
        if (go) begin
            pc_next = cond_hit ? ctrl.target : pc_reg + 4'd1;
            if (ctrl.ch_clr) begin
                ch_next = '0;
            end else if (ctrl.ch_inc) begin
                ch_next = ch_reg + 1'b1;
            end
        end
    end

    // output register next state
    always_comb begin
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        if (ctrl.emit && go) begin
            m_valid_next = 1'b1;
            m_byte_next  = b_sel;
            m_last_next  = (ctrl.sel == SEL_SUM) && !more_after;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // set command write
    assign set_in_range = ({1'b0, s_channel} < (CH_W + 1)'(NUM_CHANNELS));
    assign set_fire     = ctrl.accept && s_valid && (s_command == CMD_SET) && set_in_range;

    // control and table registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= STEP_FETCH;
            ch_reg      <= '0;
            m_valid_reg <= 1'b0;
            enabled_reg <= '0;
            pending_reg <= '1;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                drive_reg[i] <= '0;
            end
        end else begin
            pc_reg      <= pc_next;
            ch_reg      <= ch_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                enabled_reg <= cfg_wr_data;
            end
            if (set_fire) begin
                pending_reg[rd_idx] <= (rd_val != s_drive_value);
                drive_reg[rd_idx]   <= s_drive_value;
            end
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
    end

    assign s_ready      = ctrl.accept;
    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_last_byte  = m_last_reg;

endmodule

`default_nettype wire

// ===== rtl/mcps_checker.sv =====
// mcps_checker: port-level assertions for the motor command packet scheduler
// and the bind that attaches them; depends on mcps_pkg
`default_nettype none

module mcps_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               cfg_wr_en,
    input wire logic [mcps_pkg::CFG_W-1:0]         cfg_wr_data,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               s_command,
    input wire logic [mcps_pkg::CH_W-1:0]          s_channel,
    input wire logic signed [mcps_pkg::DRIVE_W-1:0] s_drive_value,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [mcps_pkg::BYTE_W-1:0]        m_frame_byte,
    input wire logic                               m_last_byte
);
    import mcps_pkg::*;

    // output is empty right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("frame byte valid right after reset");

    // a stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte)
                                && $stable(m_last_byte))
        else $error("stalled frame byte changed");

    // a transmit transfer blocks the command channel while it scans
    a_xmit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_XMIT) |=> !s_ready)
        else $error("command taken during transmit scan");

    // after a set transfer the command channel is ready again in the next cycle
    a_set_quick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_SET) |=> s_ready)
        else $error("set command did not return to fetch");

endmodule

bind motor_command_packet_scheduler mcps_checker u_mcps_checker (.*);

`default_nettype wire
